// ===== rtl/core/direct_mapped_key_value_table_assert.svh =====
// Assertion macros used by the checker file of the key/value table.
`ifndef DIRECT_MAPPED_KEY_VALUE_TABLE_ASSERT_SVH
`define DIRECT_MAPPED_KEY_VALUE_TABLE_ASSERT_SVH

// Implication checked at every rising edge unless dis is high.
`define DMKVT_ASSERT_IMPL(label, clk, dis, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication checked at every rising edge unless dis is high.
`define DMKVT_ASSERT_NEXT(label, clk, dis, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/dmkvt_pkg.sv =====
package dmkvt_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 24;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int KB_W     = 2;
    localparam int TE_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // Commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_BOUNDS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY         = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 1'd1;

    // Key byte counts
    localparam logic [KB_W-1:0] KB_NONE  = 2'd0;
    localparam logic [KB_W-1:0] KB_ONE   = 2'd1;
    localparam logic [KB_W-1:0] KB_TWO   = 2'd2;
    localparam logic [KB_W-1:0] KB_THREE = 2'd3;

    // Reset values of the configuration registers
    localparam logic [KB_W-1:0] KB_RESET = 2'd1;
    localparam logic [TE_W-1:0] TE_RESET = 9'd256;

endpackage

// ===== rtl/core/direct_mapped_key_value_table.sv =====
// Direct-address key/value table.
// Input channel s_*: one request item (command, key, value). The low key_bytes
// bytes of the key select a slot; insert, update, get and delete act on it.
// Result channel m_*: exactly one item (status, read_value) per request,
// in request order.
// Configuration channel cfg_*: index 0 key_bytes, index 1 table_entries,
// always ready; write only while no request is in flight.
// Path: accepted requests pass the read stage, then the result register that drives m_*.
// Throughput: one request per cycle outside stalls and clearing, set by the single slot read-modify-write
// (registered memory read, one write per cycle, last write forwarded).
// Reset: configuration returns to key_bytes 1, table_entries 256, and a
// clearing pass empties the occupancy memory one slot a cycle; s_ready stays
// low until it ends. Stored values are not cleared.
// Stall: the result register holds while m_ready is low; one more request
// waits in the read stage, then s_ready drops until the result is taken.
module direct_mapped_key_value_table #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dmkvt_pkg::CMD_W-1:0]       s_command,
    input  logic [dmkvt_pkg::KEY_W-1:0]       s_key,
    input  logic [dmkvt_pkg::VAL_W-1:0]       s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dmkvt_pkg::STATUS_W-1:0]    m_status,
    output logic [dmkvt_pkg::VAL_W-1:0]       m_read_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmkvt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmkvt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dmkvt_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [KEY_W:0] DEPTH_W = (KEY_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Configuration registers
    logic [KB_W-1:0] key_bytes_reg;
    logic [TE_W-1:0] table_entries_reg;

    // Clearing pass
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    // Memories
    logic                  occ_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];
    logic                  occ_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;

    // Read stage
    logic                  st1_valid_reg;
    logic [CMD_W-1:0]      st1_cmd_reg;
    logic [IDX_W-1:0]      st1_idx_reg;
    logic                  st1_oob_reg;
    logic [VALUE_BITS-1:0] st1_val_reg;
    logic                  byp_reg;
    logic                  byp_occ_reg;
    logic [VALUE_BITS-1:0] byp_val_reg;

    // Result register
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [VAL_W-1:0]      m_read_value_reg;

    logic                  s_accept;
    logic                  st1_commit;
    logic [KEY_W-1:0]      key_masked;
    logic [KEY_W:0]        bound;
    logic                  s_oob;
    logic [IDX_W-1:0]      s_idx;
    logic [63:0]           val_in64;
    logic                  cur_occ;
    logic [VALUE_BITS-1:0] cur_val;
    logic [63:0]           cur_val64;
    logic                  wr_req;
    logic                  wr_en;
    logic                  wr_occ;
    logic [VALUE_BITS-1:0] wr_val;
    logic [STATUS_W-1:0]   status_next;
    logic [VAL_W-1:0]      read_value_next;
    logic                  byp_next;

    // Handshakes
    assign st1_commit = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !clr_busy_reg && (!st1_valid_reg || st1_commit);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;

    // Slot index and bounds check
    always_comb begin
        case (key_bytes_reg)
            KB_NONE:  key_masked = '0;
            KB_ONE:   key_masked = {16'h0, s_key[7:0]};
            KB_TWO:   key_masked = {8'h0, s_key[15:0]};
            default:  key_masked = s_key;
        endcase
    end

    assign bound    = ((KEY_W + 1)'(table_entries_reg) > DEPTH_W) ?
                      DEPTH_W : (KEY_W + 1)'(table_entries_reg);
    assign s_oob    = {1'b0, key_masked} >= bound;
    assign s_idx    = key_masked[IDX_W-1:0];
    assign val_in64 = {32'h0, s_value};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg     <= KB_RESET;
            table_entries_reg <= TE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KEY_BYTES:     key_bytes_reg     <= cfg_data[KB_W-1:0];
                CFG_TABLE_ENTRIES: table_entries_reg <= cfg_data[TE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clearing pass over the occupancy memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_IDX) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Occupancy memory
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            occ_mem[clr_cnt_reg] <= 1'b0;
        end else if (wr_en) begin
            occ_mem[st1_idx_reg] <= wr_occ;
        end
        if (s_accept) begin
            occ_rd_reg <= occ_mem[s_idx];
        end
    end

    // Value memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            val_mem[st1_idx_reg] <= wr_val;
        end
        if (s_accept) begin
            val_rd_reg <= val_mem[s_idx];
        end
    end

    // Slot state seen by the read stage, with the last write forwarded
    assign cur_occ   = byp_reg ? byp_occ_reg : occ_rd_reg;
    assign cur_val   = byp_reg ? byp_val_reg : val_rd_reg;
    assign cur_val64 = 64'(cur_val);

    // Command decode
    always_comb begin
        wr_req          = 1'b0;
        wr_occ          = 1'b0;
        wr_val          = '0;
        status_next     = ST_OK;
        read_value_next = '0;
        if (st1_oob_reg) begin
            status_next = ST_OUT_OF_BOUNDS;
        end else begin
            case (st1_cmd_reg)
                CMD_INSERT: begin
                    if (cur_occ) begin
                        status_next = ST_OCCUPIED;
                    end else begin
                        wr_req = 1'b1;
                        wr_occ = 1'b1;
                        wr_val = st1_val_reg;
                    end
                end
                CMD_UPDATE: begin
                    wr_req = 1'b1;
                    wr_occ = 1'b1;
                    wr_val = st1_val_reg;
                end
                CMD_GET: begin
                    if (cur_occ) begin
                        read_value_next = cur_val64[VAL_W-1:0];
                    end else begin
                        status_next = ST_EMPTY;
                    end
                end
                default: begin
                    if (cur_occ) begin
                        wr_req = 1'b1;
                    end else begin
                        status_next = ST_EMPTY;
                    end
                end
            endcase
        end
    end

    assign wr_en    = st1_commit && wr_req;
    assign byp_next = wr_en && (s_idx == st1_idx_reg);

    // Read stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_commit) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_cmd_reg <= s_command;
            st1_idx_reg <= s_idx;
            st1_oob_reg <= s_oob;
            st1_val_reg <= val_in64[VALUE_BITS-1:0];
            byp_reg     <= byp_next;
            byp_occ_reg <= wr_occ;
            byp_val_reg <= wr_val;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_commit) begin
            m_status_reg     <= status_next;
            m_read_value_reg <= read_value_next;
        end
    end

endmodule

// ===== rtl/core/dmkvt_checker.sv =====
`include "direct_mapped_key_value_table_assert.svh"

module dmkvt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [dmkvt_pkg::STATUS_W-1:0]    m_status,
    input logic [dmkvt_pkg::VAL_W-1:0]       m_read_value
);
    import dmkvt_pkg::*;

    // A stalled result item holds
    `DMKVT_ASSERT_NEXT(a_result_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_read_value), "result item changed while stalled")

    // Only a successful get carries data
    `DMKVT_ASSERT_IMPL(a_zero_on_fail, aclk, !aresetn, m_valid && m_status != ST_OK, m_read_value == '0, "nonzero read_value on a failed request")

    // A new result item follows an accepted request through the read stage and the result register
    `DMKVT_ASSERT_IMPL(a_result_origin, aclk, !aresetn, $rose(m_valid), $past(s_valid && s_ready, 2), "result item without a matching request")

    // The occupancy clear keeps requests out right after reset
    `DMKVT_ASSERT_IMPL(a_clear_blocks, aclk, 1'b0, $rose(aresetn), !s_ready && !m_valid, "request path open right after reset")

endmodule

bind direct_mapped_key_value_table dmkvt_checker u_dmkvt_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dmkvt_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOT_SLOTS = 12;
    // Life of one key: insert, get, second insert, update, get, delete, get, delete
    localparam logic [8*CMD_W-1:0] KEY_LIFECYCLE = {CMD_DELETE, CMD_GET, CMD_DELETE, CMD_GET,
                                                    CMD_UPDATE, CMD_INSERT, CMD_GET, CMD_INSERT};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    read_value;
    } reply_t;

    typedef struct packed {
        bit                    is_cfg;
        logic [CMD_W-1:0]      cmd;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
        bit                    typed;
        reply_t                reply;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command = CMD_INSERT;
    logic [KEY_W-1:0]      s_key = '0;
    logic [VAL_W-1:0]      s_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [VAL_W-1:0]      m_read_value;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_KEY_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the table and its registers
    logic [KB_W-1:0]  key_bytes_cfg = KB_RESET;
    logic [TE_W-1:0]  table_entries_cfg = TE_RESET;
    bit               slot_used [TABLE_DEPTH];
    logic [VAL_W-1:0] slot_data [TABLE_DEPTH];

    reply_t      pending_replies [$];
    stim_row_t   directed_rows [$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned ready_hold = 0;
    int unsigned hot_base = 0;
    int unsigned hot_span = 1;

    direct_mapped_key_value_table #(
        .DEPTH(TABLE_DEPTH),
        .VALUE_BITS(VAL_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_key(s_key),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_value(m_read_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(99, 0) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
            ready_hold = pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker: oldest expectation first
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result item: status %0d read_value %h", m_status, m_read_value);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_read_value !== want.read_value) begin
                    $error("read_value mismatch: expected %h, got %h",
                           want.read_value, m_read_value);
                    fail_count++;
                end
            end
        end
    end

    // Slots in use: table_entries clipped to the depth
    function automatic logic [TE_W-1:0] effective_entries();
        return (table_entries_cfg > TE_W'(TABLE_DEPTH)) ? TE_W'(TABLE_DEPTH)
                                                         : table_entries_cfg;
    endfunction

    // Applies one request to the shadow table and returns its reply
    function automatic reply_t predict_table_access(logic [CMD_W-1:0] cmd,
                                                    logic [KEY_W-1:0] key,
                                                    logic [VAL_W-1:0] value);
        reply_t r;
        logic [KEY_W-1:0] slot;
        logic [SLOT_W-1:0] slot_at;
        r.status = ST_OK;
        r.read_value = '0;
        case (key_bytes_cfg)
            KB_NONE: slot = '0;
            KB_ONE:  slot = {16'h0, key[7:0]};
            KB_TWO:  slot = {8'h0, key[15:0]};
            default: slot = key;
        endcase
        slot_at = slot[SLOT_W-1:0];
        if (slot >= KEY_W'(effective_entries())) begin
            r.status = ST_OUT_OF_BOUNDS;
        end else begin
            case (cmd)
                CMD_INSERT: begin
                    if (slot_used[slot_at]) begin
                        r.status = ST_OCCUPIED;
                    end else begin
                        slot_data[slot_at] = value;
                        slot_used[slot_at] = 1'b1;
                    end
                end
                CMD_UPDATE: begin
                    slot_data[slot_at] = value;
                    slot_used[slot_at] = 1'b1;
                end
                CMD_GET: begin
                    if (!slot_used[slot_at])
                        r.status = ST_EMPTY;
                    else
                        r.read_value = slot_data[slot_at];
                end
                CMD_DELETE: begin
                    if (!slot_used[slot_at]) begin
                        r.status = ST_EMPTY;
                    end else begin
                        slot_data[slot_at] = '0;
                        slot_used[slot_at] = 1'b0;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // Sends one request item; the reply is queued at the accepting edge
    task automatic drive_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] value, bit typed, reply_t typed_reply);
        int unsigned gap;
        reply_t predicted;
        gap = ($urandom_range(99, 0) < gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_key <= key;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_table_access(cmd, key, value);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (index == CFG_KEY_BYTES)
            key_bytes_cfg = data[KB_W-1:0];
        else
            table_entries_cfg = data[TE_W-1:0];
    endtask

    // Drain all replies, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return $urandom();
    endfunction

    // Key biased toward a hot window of slots and the table edge
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        logic [31:0] slot;
        int unsigned roll;
        int unsigned limit;
        k = KEY_W'($urandom());
        limit = 32'(effective_entries());
        roll = $urandom_range(99, 0);
        if (roll >= 85)
            return k;
        if (roll < 75)
            slot = hot_base + $urandom_range(hot_span - 1, 0);
        else if (limit == 0)
            slot = $urandom_range(1, 0);
        else
            slot = limit - 1 + $urandom_range(2, 0);
        case (key_bytes_cfg)
            KB_ONE:   k[7:0] = slot[7:0];
            KB_TWO:   k[15:0] = slot[15:0];
            KB_THREE: k = slot[KEY_W-1:0];
            default:  ;
        endcase
        return k;
    endfunction

    function automatic stim_row_t req_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.cmd = cmd;
        row.key = key;
        row.value = value;
        return row;
    endfunction

    function automatic stim_row_t chk_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] value, logic [STATUS_W-1:0] status,
                                          logic [VAL_W-1:0] read_value);
        stim_row_t row;
        row = req_row(cmd, key, value);
        row.typed = 1'b1;
        row.reply.status = status;
        row.reply.read_value = read_value;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] index,
                                          logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg_index = index;
        row.cfg_data = data;
        return row;
    endfunction

    initial begin
        stim_row_t row;
        bit cfg_open;
        logic [KEY_W-1:0] key;
        logic [CMD_W-1:0] cmd;
        logic [CFG_DATA_W-1:0] kb_data;
        logic [CFG_DATA_W-1:0] te_data;
        int unsigned sent;
        int unsigned steps;
        int unsigned limit;

        // Empty table, default registers: basic command behavior
        directed_rows.push_back(chk_row(CMD_GET, 24'h000005, 32'h0, ST_EMPTY, 32'h0));
        directed_rows.push_back(chk_row(CMD_DELETE, 24'h000005, 32'h0, ST_EMPTY, 32'h0));
        directed_rows.push_back(chk_row(CMD_INSERT, 24'h000005, 32'hFFFFFFFF, ST_OK, 32'h0));
        directed_rows.push_back(chk_row(CMD_INSERT, 24'hFFFF05, 32'h0, ST_OCCUPIED, 32'h0));
        directed_rows.push_back(chk_row(CMD_GET, 24'h123405, 32'h0, ST_OK, 32'hFFFFFFFF));
        directed_rows.push_back(req_row(CMD_UPDATE, 24'h000005, 32'hA5A5A5A5));
        directed_rows.push_back(chk_row(CMD_GET, 24'h000005, 32'h0, ST_OK, 32'hA5A5A5A5));
        directed_rows.push_back(chk_row(CMD_DELETE, 24'h000005, 32'h0, ST_OK, 32'h0));
        directed_rows.push_back(chk_row(CMD_GET, 24'h000005, 32'h0, ST_EMPTY, 32'h0));
        // Update of an empty slot at the top index
        directed_rows.push_back(chk_row(CMD_UPDATE, 24'hFFFFFF, 32'h0, ST_OK, 32'h0));
        directed_rows.push_back(chk_row(CMD_GET, 24'h0000FF, 32'h0, ST_OK, 32'h0));
        directed_rows.push_back(req_row(CMD_INSERT, 24'h000000, 32'h5A5A5A5A));
        directed_rows.push_back(req_row(CMD_INSERT, 24'h000000, 32'h80000000));
        // No key bytes: every key lands on slot zero
        directed_rows.push_back(cfg_row(CFG_KEY_BYTES, {7'd0, KB_NONE}));
        directed_rows.push_back(chk_row(CMD_GET, 24'hABCDEF, 32'h0, ST_OK, 32'h5A5A5A5A));
        // Junk above the key byte field; table size beyond the depth
        directed_rows.push_back(cfg_row(CFG_KEY_BYTES, {7'h7F, KB_TWO}));
        directed_rows.push_back(cfg_row(CFG_TABLE_ENTRIES, 9'h1FF));
        directed_rows.push_back(chk_row(CMD_GET, 24'h0000FF, 32'h0, ST_OK, 32'h0));
        directed_rows.push_back(chk_row(CMD_INSERT, 24'h000100, 32'h1, ST_OUT_OF_BOUNDS, 32'h0));
        // Zero table size: nothing is in bounds
        directed_rows.push_back(cfg_row(CFG_TABLE_ENTRIES, 9'h000));
        directed_rows.push_back(chk_row(CMD_GET, 24'h000000, 32'h0, ST_OUT_OF_BOUNDS, 32'h0));
        directed_rows.push_back(chk_row(CMD_UPDATE, 24'h000000, 32'h12345678,
                                        ST_OUT_OF_BOUNDS, 32'h0));
        // One slot, three key bytes: out of bounds requests leave the table alone
        directed_rows.push_back(cfg_row(CFG_KEY_BYTES, {7'd0, KB_THREE}));
        directed_rows.push_back(cfg_row(CFG_TABLE_ENTRIES, 9'h001));
        directed_rows.push_back(chk_row(CMD_UPDATE, 24'h010000, 32'h0, ST_OUT_OF_BOUNDS, 32'h0));
        directed_rows.push_back(chk_row(CMD_DELETE, 24'hFFFFFF, 32'h0, ST_OUT_OF_BOUNDS, 32'h0));
        directed_rows.push_back(chk_row(CMD_GET, 24'h000000, 32'h0, ST_OK, 32'h5A5A5A5A));
        directed_rows.push_back(req_row(CMD_DELETE, 24'h000000, 32'h0));
        directed_rows.push_back(req_row(CMD_GET, 24'hFF0000, 32'h0));

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // Directed part, moderate idling
        gap_pct = 30;
        stall_pct = 30;
        cfg_open = 1'b0;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                if (!cfg_open)
                    wait_idle();
                write_register(row.cfg_index, row.cfg_data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                drive_request(row.cmd, row.key, row.value, row.typed, row.reply);
            end
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin kb_data = {7'd0, KB_ONE};   te_data = 9'd256; end
                1: begin kb_data = {7'd0, KB_NONE};  te_data = 9'd1;   end
                2: begin kb_data = {7'd0, KB_THREE}; te_data = 9'h1FF; end
                3: begin kb_data = {7'd0, KB_TWO};   te_data = 9'd0;   end
                4: begin kb_data = {7'd0, KB_ONE};   te_data = 9'd1;   end
                5: begin kb_data = {7'd0, KB_THREE}; te_data = 9'd256; end
                6: begin kb_data = {7'd0, KB_TWO};   te_data = 9'd255; end
                default: begin
                    kb_data = CFG_DATA_W'($urandom_range(511, 0));
                    te_data = ($urandom_range(99, 0) < 70) ?
                              CFG_DATA_W'($urandom_range(256, 1)) :
                              CFG_DATA_W'($urandom_range(511, 0));
                end
            endcase
            if ($urandom_range(1, 0)) begin
                write_register(CFG_KEY_BYTES, kb_data);
                write_register(CFG_TABLE_ENTRIES, te_data);
            end else begin
                write_register(CFG_TABLE_ENTRIES, te_data);
                write_register(CFG_KEY_BYTES, kb_data);
            end
            cfg_valid <= 1'b0;

            // Idling mix: none, both, sender heavy, receiver heavy
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 30; stall_pct = 30; end
                2: begin gap_pct = 60; stall_pct = 10; end
                default: begin gap_pct = 10; stall_pct = 60; end
            endcase

            // Hot window of slots for this phase
            limit = 32'(effective_entries());
            hot_span = (limit == 0) ? 1 : ((limit < HOT_SLOTS) ? limit : HOT_SLOTS);
            hot_base = (limit > hot_span) ? $urandom_range(limit - hot_span, 0) : 0;

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(99, 0) < 60) begin
                    // Lifecycle of one key, sometimes broken by a stray command
                    key = pick_key();
                    steps = $urandom_range(8, 3);
                    for (int s = 0; s < steps; s++) begin
                        cmd = KEY_LIFECYCLE[s*CMD_W +: CMD_W];
                        if ($urandom_range(99, 0) < 10)
                            cmd = CMD_W'($urandom_range(3, 0));
                        drive_request(cmd, key, rand_value(), 1'b0, '0);
                    end
                    sent += steps;
                end else begin
                    drive_request(CMD_W'($urandom_range(3, 0)), pick_key(), rand_value(),
                                  1'b0, '0);
                    sent++;
                end
            end
        end

        // Drain and report
        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dmkvt_pkg.sv
rtl/core/direct_mapped_key_value_table.sv
rtl/core/dmkvt_checker.sv
tb/sv/tb_top.sv
